// ===== rtl/iir_pkg.sv =====
// ----------------------------------------------------------------------------
// iir_pkg
// Shared widths, register index codes and command types for the third-order
// transposed direct form II IIR filter.
// ----------------------------------------------------------------------------
package iir_pkg;

    localparam int ORDER      = 3;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int FRAC_W     = 14;
    localparam int STATE_W    = 40;
    localparam int PROD_W     = COEF_W + SAMPLE_W;
    localparam int CFG_IDX_W  = 3;

    // Register index codes: b0..b3 first, then a1..a3
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_B0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_A1 = CFG_IDX_W'(ORDER + 1);

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_W);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [STATE_W-1:0]  t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load_x;   // capture a new input sample
        logic calc;     // form y, load the output register, register b*x
        logic update;   // advance the delay state
    } t_dp_cmd;

endpackage

// ===== rtl/iir_ctrl.sv =====
// ----------------------------------------------------------------------------
// iir_ctrl
// Sequencer for the filter: input and output handshake and datapath commands.
// ----------------------------------------------------------------------------
module iir_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output iir_pkg::t_dp_cmd o_cmd
);
    import iir_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEEDFWD,
        S_UPDATE
    } t_state_e;

    t_state_e r_state;
    t_state_e n_state;
    logic     r_out_valid;
    logic     n_out_valid;
    logic     take_in;
    logic     out_free;
    logic     can_take;

    assign can_take = (r_state == S_IDLE) || (r_state == S_UPDATE);
    assign take_in  = can_take && i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd.load_x = take_in;
        o_cmd.calc   = (r_state == S_FEEDFWD) && out_free;
        o_cmd.update = (r_state == S_UPDATE);

        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take_in) n_state = S_FEEDFWD;
            end
            S_FEEDFWD: begin
                if (out_free) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = take_in ? S_FEEDFWD : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = r_out_valid;
        if (o_cmd.calc) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = !can_take;
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/iir_dp.sv =====
// ----------------------------------------------------------------------------
// iir_dp
// Filter datapath: coefficient registers, delay state, multipliers,
// rounding and saturation, output register.
// ----------------------------------------------------------------------------
module iir_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  iir_pkg::t_dp_cmd               i_cmd,
    input  logic                           i_cfg_we,
    input  logic [iir_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic signed [iir_pkg::COEF_W-1:0]   i_cfg_data,
    input  logic signed [iir_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic signed [iir_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                           o_clipped
);
    import iir_pkg::*;

    localparam int ACC_W = STATE_W + 1;
    localparam int RND_W = ACC_W - FRAC_W;
    localparam int SUM_W = STATE_W + 2;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (FRAC_W - 1));
    localparam logic signed [RND_W-1:0] Y_MAX    = RND_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] Y_MIN    = -RND_W'(1 << (SAMPLE_W - 1));

    t_coef   r_coef_b [0:ORDER];
    t_coef   r_coef_a [1:ORDER];
    t_state  r_z      [0:ORDER-1];
    t_prod   r_bx     [1:ORDER];
    t_sample r_x;
    t_sample r_y;
    t_sample r_sample_out;
    logic    r_clipped;

    t_prod                   b0x;
    t_prod                   ay     [1:ORDER];
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [RND_W-1:0] y_full;
    t_sample                 y_sat;
    logic                    y_clip;
    logic signed [SUM_W-1:0] z_sum  [0:ORDER-1];

    // Feedforward tap zero and the rounded, saturated output
    always_comb begin
        b0x     = r_coef_b[0] * r_x;
        acc     = ACC_W'(b0x) + ACC_W'(r_z[0]);
        acc_rnd = acc + RND_HALF;
        y_full  = acc_rnd[ACC_W-1:FRAC_W];
        priority if (y_full > Y_MAX) begin
            y_sat  = SAMPLE_W'(Y_MAX);
            y_clip = 1'b1;
        end else if (y_full < Y_MIN) begin
            y_sat  = SAMPLE_W'(Y_MIN);
            y_clip = 1'b1;
        end else begin
            y_sat  = y_full[SAMPLE_W-1:0];
            y_clip = 1'b0;
        end
    end

    // Feedback products and next delay state
    always_comb begin
        for (int j = 1; j <= ORDER; j++) begin
            ay[j] = r_coef_a[j] * r_y;
        end
        for (int j = 0; j < ORDER - 1; j++) begin
            z_sum[j] = SUM_W'(r_z[j+1]) + SUM_W'(r_bx[j+1]) - SUM_W'(ay[j+1]);
        end
        z_sum[ORDER-1] = SUM_W'(r_bx[ORDER]) - SUM_W'(ay[ORDER]);
    end

    // Coefficients and delay state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_b[0] <= COEF_ONE;
            for (int j = 1; j <= ORDER; j++) begin
                r_coef_b[j] <= '0;
                r_coef_a[j] <= '0;
            end
            for (int j = 0; j < ORDER; j++) begin
                r_z[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                for (int j = 0; j <= ORDER; j++) begin
                    if (i_cfg_index == CFG_IDX_B0 + CFG_IDX_W'(j)) r_coef_b[j] <= i_cfg_data;
                end
                for (int j = 1; j <= ORDER; j++) begin
                    if (i_cfg_index == CFG_IDX_A1 + CFG_IDX_W'(j - 1)) begin
                        r_coef_a[j] <= i_cfg_data;
                    end
                end
            end
            if (i_cmd.update) begin
                for (int j = 0; j < ORDER; j++) begin
                    r_z[j] <= z_sum[j][STATE_W-1:0];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) r_x <= i_sample_in;
        if (i_cmd.calc) begin
            r_y          <= y_sat;
            r_sample_out <= y_sat;
            r_clipped    <= y_clip;
            for (int j = 1; j <= ORDER; j++) begin
                r_bx[j] <= r_coef_b[j] * r_x;
            end
        end
    end

    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

endmodule

// ===== rtl/iir_filter_transposed_df2.sv =====
// ----------------------------------------------------------------------------
// iir_filter_transposed_df2
// Third-order IIR filter, transposed direct form II, Q3.14 coefficients,
// 16-bit saturating output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_sample_in): a request is taken
//   at a rising edge with valid high and stall low. Output channel
//   (o_out_valid / i_out_stall / o_sample_out, o_clipped): one result per
//   request, in order; o_clipped marks a saturated sample.
//   Timing: a taken request moves to the feedforward state, which forms
//   y = round(b0*x + z0), loads the result register and registers b*x once
//   that register is free; the update state then runs the a*y feedback
//   products and the state update, and can take the next request. The
//   feedback loop through y and the delay state is why no request is taken in the feedforward state.
//   Configuration: write coefficients through i_cfg_valid / o_cfg_ready,
//   index 0..3 for b0..b3, 4..6 for a1..a3; other indexes are dropped.
//   Write only while no request is in flight. Ready is always high.
//   Reset (i_rst_n low, synchronous): clear the delay state, set b0 to one
//   and all other coefficients to zero, drop any pending result.
//   Receiver stall: the result register holds; one more request can be
//   taken and then waits until the held result leaves.
// ----------------------------------------------------------------------------
module iir_filter_transposed_df2 (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [iir_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [iir_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                o_clipped,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [iir_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic signed [iir_pkg::COEF_W-1:0]   i_cfg_data
);
    import iir_pkg::*;

    t_dp_cmd cmd;

    // Coefficient writes are plain register loads
    assign o_cfg_ready = 1'b1;

    iir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    iir_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

endmodule

// ===== rtl/iir_chk.sv =====
// ----------------------------------------------------------------------------
// iir_chk
// Port-level checks for the IIR filter, bound to the top level.
// ----------------------------------------------------------------------------
module iir_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [iir_pkg::SAMPLE_W-1:0] o_sample_out,
    input logic                                o_clipped
);
    import iir_pkg::*;

    // A stalled result stays valid
    a_out_valid_hold: assert property (@(posedge i_clk)
        (i_rst_n && o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_data_hold: assert property (@(posedge i_clk)
        (i_rst_n && o_out_valid && i_out_stall) |=>
            ($stable(o_sample_out) && $stable(o_clipped)))
        else $error("result changed while stalled");

    // One sample in work at a time: a taken request blocks the next cycle
    a_in_spacing: assert property (@(posedge i_clk)
        (i_rst_n && i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("requests taken back to back");

    // A clipped result sits at one of the rails
    a_clip_rail: assert property (@(posedge i_clk)
        (i_rst_n && o_out_valid && o_clipped) |->
            (o_sample_out == 16'sh7fff || o_sample_out == 16'sh8000))
        else $error("clipped flag without a rail value");

    // Reset drops any pending result
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind iir_filter_transposed_df2 iir_chk u_iir_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_sample_out (o_sample_out),
    .o_clipped    (o_clipped)
);

// ===== bench/iir_filter_transposed_df2_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iir_filter_transposed_df2_tb
// Self-checking bench for the third-order transposed DF-II IIR filter. Drives
// directed and random sample streams under several coefficient sets, gaps
// the input and stalls the output at random, and checks every output sample
// and clip flag against a cycle-free fixed-point predictor in a scoreboard.
// ----------------------------------------------------------------------------
module iir_filter_transposed_df2_tb;

    import iir_pkg::*;

    // Register index codes, laid out as b0..b3 then a1..a3
    localparam logic [CFG_IDX_W-1:0] IDX_B0     = CFG_IDX_B0;
    localparam logic [CFG_IDX_W-1:0] IDX_B1     = CFG_IDX_B0 + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] IDX_B2     = CFG_IDX_B0 + CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] IDX_B3     = CFG_IDX_B0 + CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] IDX_A1     = CFG_IDX_A1;
    localparam logic [CFG_IDX_W-1:0] IDX_A2     = CFG_IDX_A1 + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] IDX_A3     = CFG_IDX_A1 + CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = CFG_IDX_A1 + CFG_IDX_W'(3);

    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -(longint'(1) << (SAMPLE_W - 1));
    localparam longint HALF_LSB   = longint'(1) << (FRAC_W - 1);

    localparam t_coef   COEF_MAX = {1'b0, {(COEF_W - 1){1'b1}}};
    localparam t_coef   COEF_MIN = {1'b1, {(COEF_W - 1){1'b0}}};
    localparam t_sample X_MAX    = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam t_sample X_MIN    = {1'b1, {(SAMPLE_W - 1){1'b0}}};

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;

    typedef enum int {COEFS_MILD, COEFS_FULL, COEFS_EXTREME} coef_mix_e;

    typedef struct {
        t_sample sample;
        logic    clipped;
    } filt_out_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks coefficients and delay line, queues expected outputs
    // ------------------------------------------------------------------------
    class filter_scoreboard;
        longint    coef_b [ORDER + 1];
        longint    coef_a [ORDER + 1];
        longint    delay  [ORDER];
        filt_out_t pending_outputs [$];
        int        mismatches;

        function new();
            foreach (coef_b[k]) coef_b[k] = 0;
            foreach (coef_a[k]) coef_a[k] = 0;
            foreach (delay[k])  delay[k]  = 0;
            coef_b[0]  = longint'(COEF_ONE);
            mismatches = 0;
        endfunction

        function void set_coef(logic [CFG_IDX_W-1:0] idx, t_coef value);
            case (idx)
                IDX_B0: coef_b[0] = longint'(value);
                IDX_B1: coef_b[1] = longint'(value);
                IDX_B2: coef_b[2] = longint'(value);
                IDX_B3: coef_b[3] = longint'(value);
                IDX_A1: coef_a[1] = longint'(value);
                IDX_A2: coef_a[2] = longint'(value);
                IDX_A3: coef_a[3] = longint'(value);
                default: ;  // drop writes to unknown indexes
            endcase
        endfunction

        // Run one sample through the filter and queue the output it yields
        function void take_sample(t_sample x_in);
            longint    x;
            longint    acc;
            longint    rounded;
            longint    y;
            filt_out_t res;
            x       = longint'(x_in);
            acc     = coef_b[0] * x + delay[0];
            rounded = (acc + HALF_LSB) >>> FRAC_W;
            y       = rounded;
            if (y > SAMPLE_MAX) begin
                y = SAMPLE_MAX;
            end else if (y < SAMPLE_MIN) begin
                y = SAMPLE_MIN;
            end
            for (int j = 0; j < ORDER - 1; j++) begin
                delay[j] = delay[j + 1] + coef_b[j + 1] * x - coef_a[j + 1] * y;
            end
            delay[ORDER - 1] = coef_b[ORDER] * x - coef_a[ORDER] * y;
            res.sample  = t_sample'(y);
            res.clipped = (y != rounded);
            pending_outputs.insert(pending_outputs.size(), res);
        endfunction

        function void match_output(t_sample got_sample, logic got_clipped);
            filt_out_t want;
            if (pending_outputs.size() == 0) begin
                $error("sample_out: result with no request pending (got %0d)", got_sample);
                mismatches++;
                return;
            end
            want = pending_outputs.pop_front();
            if (got_sample !== want.sample) begin
                $error("sample_out: expected %0d, actual %0d", want.sample, got_sample);
                mismatches++;
            end
            if (got_clipped !== want.clipped) begin
                $error("clipped: expected %0b, actual %0b", want.clipped, got_clipped);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_outputs.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    t_sample                 i_sample_in;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    t_sample                 o_sample_out;
    logic                    o_clipped;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    t_coef                   i_cfg_data;

    iir_filter_transposed_df2 i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    filter_scoreboard sb;
    int               in_idle_pct  = 38;
    int               out_idle_pct = 38;
    int               hold_cycles  = 0;
    int               cycle_count  = 0;

    // ------------------------------------------------------------------------
    // Monitors: sample handshakes with the values present before the edge.
    // Check the output first; a request taken at this edge cannot have its
    // result out yet.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.match_output(o_sample_out, o_clipped);
            end
            if (i_in_valid && !o_in_stall) begin
                sb.take_sample(i_sample_in);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_coef(i_cfg_index, i_cfg_data);
            end
        end
    end

    // Watchdog: end the run if it hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall at random, or hold off for a counted stretch on demand
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles--;
            end else begin
                i_out_stall <= ($urandom_range(99) < out_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks; every task is entered and left at a rising edge
    // ------------------------------------------------------------------------

    // Offer one request, maybe after a short gap, and hold it until taken
    task automatic send_sample(input t_sample x);
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stop sending and wait until every expected output has come back;
    // first wait for a rising edge so the monitor has queued the last request
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input t_coef value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Write all seven coefficients back to back, plus one stray index
    task automatic load_coefs(input t_coef b0, b1, b2, b3, a1, a2, a3);
        write_coef(IDX_B0, b0);
        write_coef(IDX_B1, b1);
        write_coef(IDX_B2, b2);
        write_coef(IDX_B3, b3);
        write_coef(IDX_A1, a1);
        write_coef(IDX_A2, a2);
        write_coef(IDX_A3, a3);
        write_coef(IDX_UNUSED, t_coef'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_coef pick_coef(input coef_mix_e mix);
        case (mix)
            COEFS_MILD: return t_coef'(int'($urandom_range(16384)) - 8192);
            COEFS_FULL: return t_coef'($urandom);
            default: begin
                case ($urandom_range(3))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    2:       return '0;
                    default: return t_coef'($urandom);
                endcase
            end
        endcase
    endfunction

    // Mostly full-range noise, some small signals, some rail and near-zero values
    function automatic t_sample pick_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) begin
            return t_sample'($urandom);
        end else if (sel < 80) begin
            return t_sample'(int'($urandom_range(512)) - 256);
        end
        case ($urandom_range(4))
            0:       return X_MAX;
            1:       return X_MIN;
            2:       return '0;
            3:       return t_sample'(1);
            default: return t_sample'(-1);
        endcase
    endfunction

    // Drain, load a fresh coefficient set at the given effective order,
    // then stream random samples; optionally hold off the receiver midway
    task automatic run_random_phase(input coef_mix_e mix, input int order,
                                    input int n_items, input int hold_at);
        t_coef c [7];
        foreach (c[k]) c[k] = pick_coef(mix);
        if (order < 3) begin
            c[3] = '0;
            c[6] = '0;
        end
        if (order < 2) begin
            c[2] = '0;
            c[5] = '0;
        end
        drain();
        load_coefs(c[0], c[1], c[2], c[3], c[4], c[5], c[6]);
        for (int k = 0; k < n_items; k++) begin
            if (k == hold_at) begin
                hold_cycles = 150;
            end
            send_sample(pick_sample());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset coefficients pass samples straight through: hit both rails
        // and alternating bit patterns
        send_sample('0);
        send_sample(t_sample'(1));
        send_sample(t_sample'(-1));
        send_sample(X_MAX);
        send_sample(X_MIN);
        send_sample(t_sample'(16'h5555));
        send_sample(t_sample'(16'hAAAA));

        // Gain of one half: exercise round half up on both signs
        drain();
        load_coefs(COEF_ONE >>> 1, '0, '0, '0, '0, '0, '0);
        send_sample(t_sample'(1));
        send_sample(t_sample'(-1));
        send_sample(t_sample'(3));
        send_sample(t_sample'(-3));

        // All coefficients at their rails: saturate both ways and drive the
        // delay line to its largest magnitudes
        drain();
        load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
        send_sample(X_MAX);
        send_sample(X_MIN);
        send_sample(X_MAX);
        send_sample(X_MIN);
        send_sample('0);
        send_sample('0);
        send_sample(t_sample'(1));
        send_sample(t_sample'(-1));

        // Random streams across coefficient mixes and effective orders
        run_random_phase(COEFS_MILD,    3, 190, -1);
        run_random_phase(COEFS_FULL,    3, 160, 50);
        run_random_phase(COEFS_EXTREME, 3, 150, -1);

        // Full rate on both sides for one whole phase
        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_random_phase(COEFS_MILD,    2, 150, -1);
        in_idle_pct  = 38;
        out_idle_pct = 38;

        run_random_phase(COEFS_MILD,    1, 150, -1);
        run_random_phase(COEFS_FULL,    2, 150, 20);
        run_random_phase(COEFS_EXTREME, 1, 140, -1);
        run_random_phase(COEFS_MILD,    3, 190, -1);

        drain();
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
